// ===== src/pdst_pkg.sv =====
// ----------------------------------------------------------------------------
// pdst_pkg
// Shared types, constants and fixed-point helpers for the porous drag block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdst_pkg;

    localparam int QF        = 40;
    localparam int DIV_STEPS = 64;

    localparam logic [63:0] ONE_Q40  = 64'd1 << QF;
    localparam logic [63:0] PART_CAP = 64'd1 << 60;
    localparam logic [63:0] KC_NUM   = 64'd15 << 15;
    localparam logic [31:0] KC_RESET = 32'd65536;

    localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

    typedef enum logic {
        REG_ENABLE = 1'b0,
        REG_KC     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        [40:0] por_a;
        logic        [40:0] por_b;
        logic        [47:0] diam_a;
        logic        [47:0] diam_b;
        logic        [47:0] lin_coef_a;
        logic        [47:0] lin_coef_b;
        logic        [47:0] quad_coef_a;
        logic        [47:0] quad_coef_b;
        logic        [47:0] visc_a;
        logic        [47:0] visc_b;
        logic signed [47:0] velocity;
        logic signed [47:0] rhs_in;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] rhs_out;
        logic               saturated;
    } out_word_t;

    // everything an item carries down the pipeline
    typedef struct packed {
        logic               en;
        logic signed [47:0] rhs;
        logic        [47:0] umag;
        logic               uneg;
        logic               uzero;
        logic               neg_b;
        logic               ov;
        logic               flag;
        logic        [63:0] n;
        logic        [63:0] d;
        logic        [63:0] alpha;
        logic        [63:0] beta;
        logic        [63:0] visc;
        logic        [63:0] om;
        logic        [63:0] r;
        logic        [63:0] x;
        logic        [63:0] y;
        logic        [63:0] k;
        logic        [63:0] bk;
        logic        [63:0] rn;
        logic        [63:0] xb;
        logic        [63:0] ax;
        logic        [63:0] bx;
        logic        [63:0] a;
        logic        [63:0] u2;
        logic        [63:0] b;
        logic        [63:0] ta;
        logic        [63:0] tb;
    } ctx_t;

    typedef struct packed {
        logic        ov;
        logic [63:0] val;
    } fix_t;

    // (p >> sh) limited to 64 bits, all ones on overflow
    function automatic fix_t mul_fix(input logic [127:0] p, input int unsigned sh);
        fix_t f;
        f.ov  = (p >> (64 + sh)) != 128'd0;
        f.val = f.ov ? '1 : 64'(p >> sh);
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/pdst_div.sv =====
// ----------------------------------------------------------------------------
// pdst_div
// Pipelined restoring divider, (num << 40) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pdst_div #(
    parameter int LANES = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_vld,
    input  wire logic [63:0]        num [LANES],
    input  wire logic [63:0]        den [LANES],
    input  wire pdst_pkg::ctx_t     ctx_in,
    output logic                    out_vld,
    output logic [63:0]             quo [LANES],
    output logic                    ovf [LANES],
    output pdst_pkg::ctx_t          ctx_out
);
    import pdst_pkg::*;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] q;
        logic [63:0] den;
        logic        ov;
    } dstep_t;

    dstep_t st_reg  [DIV_STEPS][LANES];
    dstep_t st_next [DIV_STEPS][LANES];
    ctx_t   ctx_reg [DIV_STEPS];
    logic   vld_reg [DIV_STEPS];

    always_comb
    begin
        dstep_t      cur;
        logic [64:0] sh;
        for (int s = 0; s < DIV_STEPS; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    cur.rem = num[l] >> (64 - QF);
                    cur.lo  = num[l] << QF;
                    cur.q   = '0;
                    cur.den = den[l];
                    cur.ov  = (num[l] >> (64 - QF)) >= den[l];
                end else begin
                    cur = st_reg[s-1][l];
                end
                sh = {cur.rem, cur.lo[63]};
                st_next[s][l].den = cur.den;
                st_next[s][l].ov  = cur.ov;
                st_next[s][l].lo  = cur.lo << 1;
                if (sh >= {1'b0, cur.den}) begin
                    st_next[s][l].rem = 64'(sh - {1'b0, cur.den});
                    st_next[s][l].q   = {cur.q[62:0], 1'b1};
                end else begin
                    st_next[s][l].rem = sh[63:0];
                    st_next[s][l].q   = {cur.q[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < DIV_STEPS; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        ctx_reg[0] <= ctx_in;
        for (int s = 1; s < DIV_STEPS; s++) begin
            ctx_reg[s] <= ctx_reg[s-1];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++) begin
            ovf[l] = st_reg[DIV_STEPS-1][l].ov;
            quo[l] = st_reg[DIV_STEPS-1][l].ov ? '1 : st_reg[DIV_STEPS-1][l].q;
        end
    end

    assign out_vld = vld_reg[DIV_STEPS-1];
    assign ctx_out = ctx_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== src/pdst_mul.sv =====
// ----------------------------------------------------------------------------
// pdst_mul
// Two-stage 64x64 multiplier: 32x32 partial products, then the full sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pdst_mul #(
    parameter int LANES = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_vld,
    input  wire logic [63:0]        opa [LANES],
    input  wire logic [63:0]        opb [LANES],
    input  wire pdst_pkg::ctx_t     ctx_in,
    output logic                    out_vld,
    output logic [127:0]            prod [LANES],
    output pdst_pkg::ctx_t          ctx_out
);
    import pdst_pkg::*;

    logic [63:0]  pp_reg   [LANES][4];
    logic [127:0] prod_reg [LANES];
    ctx_t         ctx1_reg;
    ctx_t         ctx2_reg;
    logic         vld1_reg;
    logic         vld2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++) begin
            pp_reg[l][0] <= {32'd0, opa[l][31:0]}  * {32'd0, opb[l][31:0]};
            pp_reg[l][1] <= {32'd0, opa[l][31:0]}  * {32'd0, opb[l][63:32]};
            pp_reg[l][2] <= {32'd0, opa[l][63:32]} * {32'd0, opb[l][31:0]};
            pp_reg[l][3] <= {32'd0, opa[l][63:32]} * {32'd0, opb[l][63:32]};
            prod_reg[l]  <= {pp_reg[l][3], 64'd0}
                          + {32'd0, pp_reg[l][1], 32'd0}
                          + {32'd0, pp_reg[l][2], 32'd0}
                          + {64'd0, pp_reg[l][0]};
        end
        ctx1_reg <= ctx_in;
        ctx2_reg <= ctx1_reg;
    end

    assign prod    = prod_reg;
    assign out_vld = vld2_reg;
    assign ctx_out = ctx2_reg;

endmodule

`default_nettype wire

// ===== src/porous_drag_source_term.sv =====
// ----------------------------------------------------------------------------
// porous_drag_source_term
// Forchheimer porous drag on one velocity face: rhs - A*u - B*u*|u|.
//
// Input: an item word is taken at each clock edge with start high; busy
// stays low, so a new face may be issued in every cycle.
// Output: result_valid is high for one cycle with result; the receiver
// cannot hold it off and needs none: one result per face, in order.
// Datapath: the input register c0_reg, then four chained 64-step divider
// pipelines (one quotient bit per stage) and four two-stage 64x64
// multipliers, with registers c1_reg to c9_reg and res_reg between.
// Throughput: one face per clock.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects enable (0) or
// kc_number (1); cfg_ready is always high. Write only while no face is
// in flight.
// Reset: clears all valid bits in the pipeline, enable to 0 and kc_number
// to 1.0 (Q16.16).
// ----------------------------------------------------------------------------
`default_nettype none

module porous_drag_source_term (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pdst_pkg::in_word_t   item,
    output logic                      result_valid,
    output pdst_pkg::out_word_t       result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);
    import pdst_pkg::*;

    logic        enable_reg;
    logic [31:0] kc_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg <= 1'b0;
            kc_reg     <= KC_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_KC:     kc_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---------------- stage 0: averages ----------------
    ctx_t c0_reg, c0_next;
    logic v0_reg;

    always_comb
    begin
        logic [47:0] umag;
        umag = item.velocity[47] ? 48'(-item.velocity) : item.velocity;
        c0_next       = '0;
        c0_next.en    = enable_reg;
        c0_next.rhs   = item.rhs_in;
        c0_next.umag  = umag;
        c0_next.uneg  = item.velocity[47];
        c0_next.uzero = item.velocity == 48'sd0;
        c0_next.n     = 64'(({1'b0, item.por_a} + {1'b0, item.por_b}) >> 1);
        c0_next.d     = 64'(({1'b0, item.diam_a} + {1'b0, item.diam_b}) >> 1);
        c0_next.alpha = 64'(({1'b0, item.lin_coef_a} + {1'b0, item.lin_coef_b}) >> 1);
        c0_next.beta  = 64'(({1'b0, item.quad_coef_a} + {1'b0, item.quad_coef_b}) >> 1);
        c0_next.visc  = 64'(({1'b0, item.visc_a} + {1'b0, item.visc_b}) >> 1);
        c0_next.neg_b = c0_next.n > ONE_Q40;
        c0_next.om    = c0_next.neg_b ? c0_next.n - ONE_Q40 : ONE_Q40 - c0_next.n;
        c0_next.ov    = (c0_next.n == 64'd0) || (c0_next.d == 64'd0) || (kc_reg == 32'd0);
    end

    // ---------------- level 1: r, visc/d, 7.5/KC ----------------
    logic [63:0] d1_num [3], d1_den [3], d1_q [3];
    logic        d1_ov [3], d1_vld;
    ctx_t        d1_ctx, c1_reg, c1_next;
    logic        v1_reg;

    assign d1_num[0] = c0_reg.om;
    assign d1_den[0] = c0_reg.n;
    assign d1_num[1] = c0_reg.visc;
    assign d1_den[1] = c0_reg.d;
    assign d1_num[2] = KC_NUM;
    assign d1_den[2] = {32'd0, kc_reg};

    pdst_div #(.LANES(3)) u_div1 (
        .clk(clk), .rst_n(rst_n), .in_vld(v0_reg), .num(d1_num), .den(d1_den),
        .ctx_in(c0_reg), .out_vld(d1_vld), .quo(d1_q), .ovf(d1_ov), .ctx_out(d1_ctx)
    );

    always_comb
    begin
        c1_next    = d1_ctx;
        c1_next.r  = d1_q[0];
        c1_next.y  = d1_q[1];
        c1_next.k  = ONE_Q40 + d1_q[2];
        c1_next.ov = d1_ctx.ov | d1_ov[0] | d1_ov[1] | d1_ov[2];
    end

    // ---------------- level 2: r*r, beta*k ----------------
    logic [63:0]  m2_a [2], m2_b [2];
    logic [127:0] m2_p [2];
    logic         m2_vld, v2_reg;
    ctx_t         m2_ctx, c2_reg, c2_next;

    assign m2_a[0] = c1_reg.r;
    assign m2_b[0] = c1_reg.r;
    assign m2_a[1] = c1_reg.beta;
    assign m2_b[1] = c1_reg.k;

    pdst_mul #(.LANES(2)) u_mul2 (
        .clk(clk), .rst_n(rst_n), .in_vld(v1_reg), .opa(m2_a), .opb(m2_b),
        .ctx_in(c1_reg), .out_vld(m2_vld), .prod(m2_p), .ctx_out(m2_ctx)
    );

    always_comb
    begin
        fix_t f0, f1;
        f0         = mul_fix(m2_p[0], QF);
        f1         = mul_fix(m2_p[1], QF);
        c2_next    = m2_ctx;
        c2_next.x  = f0.val;
        c2_next.bk = f1.val;
        c2_next.ov = m2_ctx.ov | f0.ov | f1.ov;
    end

    // ---------------- level 3: rr/n, y/d, r/n ----------------
    logic [63:0] d3_num [3], d3_den [3], d3_q [3];
    logic        d3_ov [3], d3_vld, v3_reg;
    ctx_t        d3_ctx, c3_reg, c3_next;

    assign d3_num[0] = c2_reg.x;
    assign d3_den[0] = c2_reg.n;
    assign d3_num[1] = c2_reg.y;
    assign d3_den[1] = c2_reg.d;
    assign d3_num[2] = c2_reg.r;
    assign d3_den[2] = c2_reg.n;

    pdst_div #(.LANES(3)) u_div3 (
        .clk(clk), .rst_n(rst_n), .in_vld(v2_reg), .num(d3_num), .den(d3_den),
        .ctx_in(c2_reg), .out_vld(d3_vld), .quo(d3_q), .ovf(d3_ov), .ctx_out(d3_ctx)
    );

    always_comb
    begin
        c3_next    = d3_ctx;
        c3_next.x  = d3_q[0];
        c3_next.y  = d3_q[1];
        c3_next.rn = d3_q[2];
        c3_next.ov = d3_ctx.ov | d3_ov[0] | d3_ov[1] | d3_ov[2];
    end

    // ---------------- level 4: (r/n)/n ----------------
    logic [63:0] d4_num [1], d4_den [1], d4_q [1];
    logic        d4_ov [1], d4_vld, v4_reg;
    ctx_t        d4_ctx, c4_reg, c4_next;

    assign d4_num[0] = c3_reg.rn;
    assign d4_den[0] = c3_reg.n;

    pdst_div #(.LANES(1)) u_div4 (
        .clk(clk), .rst_n(rst_n), .in_vld(v3_reg), .num(d4_num), .den(d4_den),
        .ctx_in(c3_reg), .out_vld(d4_vld), .quo(d4_q), .ovf(d4_ov), .ctx_out(d4_ctx)
    );

    always_comb
    begin
        c4_next    = d4_ctx;
        c4_next.xb = d4_q[0];
        c4_next.ov = d4_ctx.ov | d4_ov[0];
    end

    // ---------------- level 5: alpha*x, bk*xb ----------------
    logic [63:0]  m5_a [2], m5_b [2];
    logic [127:0] m5_p [2];
    logic         m5_vld, v5_reg;
    ctx_t         m5_ctx, c5_reg, c5_next;

    assign m5_a[0] = c4_reg.alpha;
    assign m5_b[0] = c4_reg.x;
    assign m5_a[1] = c4_reg.bk;
    assign m5_b[1] = c4_reg.xb;

    pdst_mul #(.LANES(2)) u_mul5 (
        .clk(clk), .rst_n(rst_n), .in_vld(v4_reg), .opa(m5_a), .opb(m5_b),
        .ctx_in(c4_reg), .out_vld(m5_vld), .prod(m5_p), .ctx_out(m5_ctx)
    );

    always_comb
    begin
        fix_t f0, f1;
        f0         = mul_fix(m5_p[0], QF);
        f1         = mul_fix(m5_p[1], QF);
        c5_next    = m5_ctx;
        c5_next.ax = f0.val;
        c5_next.bx = f1.val;
        c5_next.ov = m5_ctx.ov | f0.ov | f1.ov;
    end

    // ---------------- level 6: A, u^2 ----------------
    logic [63:0]  m6_a [2], m6_b [2];
    logic [127:0] m6_p [2];
    logic         m6_vld, v6_reg;
    ctx_t         m6_ctx, c6_reg, c6_next;

    assign m6_a[0] = c5_reg.ax;
    assign m6_b[0] = c5_reg.y;
    assign m6_a[1] = {16'd0, c5_reg.umag};
    assign m6_b[1] = {16'd0, c5_reg.umag};

    pdst_mul #(.LANES(2)) u_mul6 (
        .clk(clk), .rst_n(rst_n), .in_vld(v5_reg), .opa(m6_a), .opb(m6_b),
        .ctx_in(c5_reg), .out_vld(m6_vld), .prod(m6_p), .ctx_out(m6_ctx)
    );

    always_comb
    begin
        fix_t f0, f1;
        f0           = mul_fix(m6_p[0], QF);
        f1           = mul_fix(m6_p[1], 32);
        c6_next      = m6_ctx;
        c6_next.a    = f0.val;
        c6_next.u2   = f1.val;
        c6_next.ov   = m6_ctx.ov | f0.ov;
        c6_next.flag = m6_ctx.flag | f1.ov;
    end

    // ---------------- level 7: B = bx/d ----------------
    logic [63:0] d7_num [1], d7_den [1], d7_q [1];
    logic        d7_ov [1], d7_vld, v7_reg;
    ctx_t        d7_ctx, c7_reg, c7_next;

    assign d7_num[0] = c6_reg.bx;
    assign d7_den[0] = c6_reg.d;

    pdst_div #(.LANES(1)) u_div7 (
        .clk(clk), .rst_n(rst_n), .in_vld(v6_reg), .num(d7_num), .den(d7_den),
        .ctx_in(c6_reg), .out_vld(d7_vld), .quo(d7_q), .ovf(d7_ov), .ctx_out(d7_ctx)
    );

    always_comb
    begin
        c7_next    = d7_ctx;
        c7_next.b  = d7_q[0];
        c7_next.ov = d7_ctx.ov | d7_ov[0];
    end

    // ---------------- level 8: A*|u|, B*u^2 ----------------
    logic [63:0]  m8_a [2], m8_b [2];
    logic [127:0] m8_p [2];
    logic         m8_vld, v8_reg;
    ctx_t         m8_ctx, c8_reg, c8_next;

    assign m8_a[0] = c7_reg.a;
    assign m8_b[0] = {16'd0, c7_reg.umag};
    assign m8_a[1] = c7_reg.b;
    assign m8_b[1] = c7_reg.u2;

    pdst_mul #(.LANES(2)) u_mul8 (
        .clk(clk), .rst_n(rst_n), .in_vld(v7_reg), .opa(m8_a), .opb(m8_b),
        .ctx_in(c7_reg), .out_vld(m8_vld), .prod(m8_p), .ctx_out(m8_ctx)
    );

    always_comb
    begin
        fix_t f0, f1;
        f0           = mul_fix(m8_p[0], QF);
        f1           = mul_fix(m8_p[1], QF);
        c8_next      = m8_ctx;
        c8_next.ta   = f0.val;
        c8_next.tb   = f1.val;
        c8_next.flag = m8_ctx.flag | f0.ov | f1.ov;
    end

    // ---------------- level 9: cap and sign the two parts ----------------
    ctx_t c9_reg, c9_next;
    logic v9_reg;

    always_comb
    begin
        logic [63:0] ta, tb;
        logic        fa, fb;
        fa           = c8_reg.ta > PART_CAP;
        fb           = c8_reg.tb > PART_CAP;
        ta           = fa ? PART_CAP : c8_reg.ta;
        tb           = fb ? PART_CAP : c8_reg.tb;
        c9_next      = c8_reg;
        c9_next.ta   = c8_reg.uneg ? 64'(-ta) : ta;
        c9_next.tb   = (c8_reg.uneg != c8_reg.neg_b) ? 64'(-tb) : tb;
        c9_next.flag = c8_reg.flag | fa | fb;
    end

    // ---------------- output: sum, clamp, special cases ----------------
    out_word_t res_reg, res_next;
    logic      res_vld_reg;

    always_comb
    begin
        logic signed [63:0] rhs64, sum;
        logic               fl;
        rhs64 = {{16{c9_reg.rhs[47]}}, c9_reg.rhs};
        sum   = rhs64 - $signed(c9_reg.ta) - $signed(c9_reg.tb);
        fl    = c9_reg.flag;
        if (sum > OUT_MAX) begin
            sum = OUT_MAX;
            fl  = 1'b1;
        end else if (sum < OUT_MIN) begin
            sum = OUT_MIN;
            fl  = 1'b1;
        end
        if (!c9_reg.en) begin
            res_next.rhs_out   = c9_reg.rhs;
            res_next.saturated = 1'b0;
        end else if (c9_reg.ov) begin
            res_next.saturated = 1'b1;
            if (c9_reg.uzero) begin
                res_next.rhs_out = c9_reg.rhs;
            end else if (c9_reg.uneg) begin
                res_next.rhs_out = OUT_MAX[47:0];
            end else begin
                res_next.rhs_out = OUT_MIN[47:0];
            end
        end else begin
            res_next.rhs_out   = sum[47:0];
            res_next.saturated = fl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            v0_reg      <= start;
            v1_reg      <= d1_vld;
            v2_reg      <= m2_vld;
            v3_reg      <= d3_vld;
            v4_reg      <= d4_vld;
            v5_reg      <= m5_vld;
            v6_reg      <= m6_vld;
            v7_reg      <= d7_vld;
            v8_reg      <= m8_vld;
            v9_reg      <= v8_reg;
            res_vld_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
        c3_reg  <= c3_next;
        c4_reg  <= c4_next;
        c5_reg  <= c5_next;
        c6_reg  <= c6_next;
        c7_reg  <= c7_next;
        c8_reg  <= c8_next;
        c9_reg  <= c9_next;
        res_reg <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire
